// File: hw/rtl/pol_pkg.sv
`default_nettype none

package pol_pkg;

    typedef logic [2:0] opcode_t;
    typedef logic [1:0] status_t;

    localparam opcode_t OP_INS_HEAD = 3'd0;
    localparam opcode_t OP_INS_TAIL = 3'd1;
    localparam opcode_t OP_INS_AT   = 3'd2;
    localparam opcode_t OP_DEL_HEAD = 3'd3;
    localparam opcode_t OP_DEL_TAIL = 3'd4;
    localparam opcode_t OP_DEL_AT   = 3'd5;
    localparam opcode_t OP_READ_ALL = 3'd6;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_OOB   = 2'd2;
    localparam status_t ST_FULL  = 2'd3;

endpackage

`default_nettype wire

// File: hw/rtl/positional_ordered_list.sv
`default_nettype none

// Channel   Direction  Ports                                            Handshake
// s_        in         s_opcode, s_item_value, s_position               s_valid / s_ready
// m_        out        m_status, m_entry_value, m_last, m_length_now    m_valid / m_ready
//
// One command at a time; s_ready is high only while the sequencer is idle.
// Insert/delete: accept, then move each shifted entry with one read then one write
// on the entry memory (separate read and write ports), then finish in S_FIN.
// Read-all: accept, then per entry a memory read (S_RA_RD) and a result register (S_RA_OUT).
// Reset clears the state, the length and the output valid; the entry memory needs no clearing pass.
// A result not yet taken holds the sequencer in its final step until m_ready.

module positional_ordered_list #(
    parameter int CAPACITY = 16
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  s_valid,
    output logic                                 s_ready,
    input  pol_pkg::opcode_t                     s_opcode,
    input  wire signed [31:0]                    s_item_value,
    input  wire        [7:0]                     s_position,
    output logic                                 m_valid,
    input  wire                                  m_ready,
    output pol_pkg::status_t                     m_status,
    output logic signed [31:0]                   m_entry_value,
    output logic                                 m_last,
    output logic [$clog2(CAPACITY + 1) - 1:0]    m_length_now
);
    import pol_pkg::*;

    localparam int LW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = ((LW > 8) ? LW : 8) + 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SH_RD  = 3'd1;
    localparam logic [2:0] S_SH_WR  = 3'd2;
    localparam logic [2:0] S_FIN    = 3'd3;
    localparam logic [2:0] S_RA_RD  = 3'd4;
    localparam logic [2:0] S_RA_OUT = 3'd5;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_INS  = 2'd1;
    localparam logic [1:0] KIND_DEL  = 2'd2;

    logic [2:0]         state_reg, state_next;
    logic [LW-1:0]      len_reg, len_next;
    logic [LW-1:0]      dst_reg, dst_next;
    logic [LW-1:0]      stop_reg, stop_next;
    logic [1:0]         kind_reg, kind_next;
    status_t            status_reg, status_next;
    logic signed [31:0] val_reg, val_next;

    logic               m_valid_reg, m_valid_next;
    status_t            m_status_reg, m_status_next;
    logic signed [31:0] m_entry_value_reg, m_entry_value_next;
    logic               m_last_reg, m_last_next;
    logic [LW-1:0]      m_length_now_reg, m_length_now_next;

    logic signed [31:0] mem [CAPACITY];
    logic signed [31:0] rdata_reg;
    logic               mem_we;
    logic [LW-1:0]      mem_waddr;
    logic signed [31:0] mem_wdata;
    logic [LW-1:0]      mem_raddr;
    logic [LW-1:0]      src;
    logic               out_free;

    logic [CW-1:0]      k_ext;
    logic [CW-1:0]      len_ext;
    logic [LW-1:0]      target;
    logic               reject;
    status_t            reject_status;

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_entry_value = m_entry_value_reg;
    assign m_last        = m_last_reg;
    assign m_length_now  = m_length_now_reg;

    assign out_free  = !m_valid_reg || m_ready;
    assign src       = (kind_reg == KIND_DEL) ? dst_reg + 1'b1 : dst_reg - 1'b1;
    // keep the read-out entry on the read port while the result stalls
    assign mem_raddr = (state_reg == S_RA_RD || state_reg == S_RA_OUT) ? dst_reg : src;

    assign k_ext   = CW'(s_position);
    assign len_ext = CW'(len_reg);

    // command decode: target index and early rejects
    always_comb begin
        target        = '0;
        reject        = 1'b0;
        reject_status = ST_OK;
        priority case (1'b1)
            (s_opcode == OP_INS_HEAD || s_opcode == OP_INS_TAIL ||
             s_opcode == OP_INS_AT): begin
                if (len_reg == LW'(CAPACITY)) begin
                    reject        = 1'b1;
                    reject_status = ST_FULL;
                end else if (s_opcode == OP_INS_TAIL) begin
                    target = len_reg;
                end else if (s_opcode == OP_INS_AT && k_ext > CW'(1)) begin
                    if (k_ext > len_ext + 1'b1) begin
                        reject        = 1'b1;
                        reject_status = ST_OOB;
                    end else begin
                        target = LW'(k_ext - 1'b1);
                    end
                end
            end
            (s_opcode == OP_DEL_HEAD || s_opcode == OP_DEL_TAIL ||
             s_opcode == OP_DEL_AT): begin
                if (len_reg == '0) begin
                    reject        = 1'b1;
                    reject_status = ST_EMPTY;
                end else if (s_opcode == OP_DEL_TAIL) begin
                    target = len_reg - 1'b1;
                end else if (s_opcode == OP_DEL_AT) begin
                    if (k_ext == '0 || k_ext > len_ext) begin
                        reject        = 1'b1;
                        reject_status = ST_OOB;
                    end else begin
                        target = LW'(k_ext - 1'b1);
                    end
                end
            end
            default: begin
                reject = 1'b1;
                if (s_opcode == OP_READ_ALL && len_reg == '0) begin
                    reject_status = ST_EMPTY;
                end
            end
        endcase
    end

    always_comb begin
        state_next         = state_reg;
        len_next           = len_reg;
        dst_next           = dst_reg;
        stop_next          = stop_reg;
        kind_next          = kind_reg;
        status_next        = status_reg;
        val_next           = val_reg;
        m_valid_next       = m_valid_reg;
        m_status_next      = m_status_reg;
        m_entry_value_next = m_entry_value_reg;
        m_last_next        = m_last_reg;
        m_length_now_next  = m_length_now_reg;
        mem_we             = 1'b0;
        mem_waddr          = dst_reg;
        mem_wdata          = rdata_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    val_next    = s_item_value;
                    status_next = reject_status;
                    if (s_opcode == OP_READ_ALL && len_reg != '0) begin
                        kind_next  = KIND_NONE;
                        dst_next   = '0;
                        state_next = S_RA_RD;
                    end else if (reject) begin
                        kind_next  = KIND_NONE;
                        state_next = S_FIN;
                    end else if (s_opcode == OP_INS_HEAD || s_opcode == OP_INS_TAIL ||
                                 s_opcode == OP_INS_AT) begin
                        // shift up from the tail down to the target slot
                        kind_next  = KIND_INS;
                        dst_next   = len_reg;
                        stop_next  = target;
                        state_next = (len_reg == target) ? S_FIN : S_SH_RD;
                    end else begin
                        // shift down from the target slot to the tail
                        kind_next  = KIND_DEL;
                        dst_next   = target;
                        stop_next  = len_reg - 1'b1;
                        state_next = (target == len_reg - 1'b1) ? S_FIN : S_SH_RD;
                    end
                end
            end
            S_SH_RD: begin
                state_next = S_SH_WR;
            end
            S_SH_WR: begin
                mem_we   = 1'b1;
                dst_next = src;
                state_next = (src == stop_reg) ? S_FIN : S_SH_RD;
            end
            S_FIN: begin
                if (out_free) begin
                    if (kind_reg == KIND_INS) begin
                        mem_we    = 1'b1;
                        mem_waddr = stop_reg;
                        mem_wdata = val_reg;
                        len_next  = len_reg + 1'b1;
                    end else if (kind_reg == KIND_DEL) begin
                        len_next  = len_reg - 1'b1;
                    end
                    m_valid_next       = 1'b1;
                    m_status_next      = status_reg;
                    m_entry_value_next = '0;
                    m_last_next        = 1'b1;
                    m_length_now_next  = len_next;
                    state_next         = S_IDLE;
                end
            end
            S_RA_RD: begin
                state_next = S_RA_OUT;
            end
            S_RA_OUT: begin
                if (out_free) begin
                    m_valid_next       = 1'b1;
                    m_status_next      = ST_OK;
                    m_entry_value_next = rdata_reg;
                    m_last_next        = (dst_reg + 1'b1 == len_reg);
                    m_length_now_next  = len_reg;
                    if (dst_reg + 1'b1 == len_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        dst_next   = dst_reg + 1'b1;
                        state_next = S_RA_RD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            len_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        dst_reg           <= dst_next;
        stop_reg          <= stop_next;
        kind_reg          <= kind_next;
        status_reg        <= status_next;
        val_reg           <= val_next;
        m_status_reg      <= m_status_next;
        m_entry_value_reg <= m_entry_value_next;
        m_last_reg        <= m_last_next;
        m_length_now_reg  <= m_length_now_next;
    end

    // entry storage, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr[AW-1:0]] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr[AW-1:0]];
    end

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LW'(CAPACITY))
        else $error("list length above capacity");

    a_len_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (len_reg == $past(len_reg) ||
                            len_reg == $past(len_reg) + 1'b1 ||
                            len_reg == $past(len_reg) - 1'b1))
        else $error("length moved by more than one");

    a_full_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg == ST_FULL) |-> m_length_now_reg == LW'(CAPACITY))
        else $error("full status with list not full");

    a_empty_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg == ST_EMPTY) |-> m_length_now_reg == '0)
        else $error("empty status with entries present");

    a_busy_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SH_RD || state_reg == S_SH_WR) |=> $stable(len_reg))
        else $error("length changed while shifting entries");

endmodule

`default_nettype wire
